[hdl/lfht_pkg.sv]
// Shared constants and types for the lowest-free handle table.
package lfht_pkg;

    // Default number of slots in the table.
    localparam int TABLE_DEPTH_DEF = 256;

    // Field widths of one request and one response.
    localparam int CMD_W    = 3;
    localparam int INDEX_W  = 10;
    localparam int HANDLE_W = 32;
    localparam int FLAGS_W  = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 9;

    // Width of a slot index widened so that it can also hold the table depth.
    localparam int WIDE_W = INDEX_W + 1;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_BITS   = CMD_W + 2 * INDEX_W + HANDLE_W + FLAGS_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = STATUS_W + SLOT_W + HANDLE_W + FLAGS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Request codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 3'd0,
        CMD_ASSIGN = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_LOOKUP = 3'd3,
        CMD_FIND   = 3'd4
    } t_cmd;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FAIL     = 2'd1,
        ST_OCCUPIED = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

endpackage

[hdl/lowest_free_handle_table_core.sv]
// Lowest-free handle table: slot memories, chunked free-slot scan and response register.

// A table of TABLE_DEPTH slots, each holding a handle and flags, driven by one request per
// transfer on the slave stream and answered by exactly one response on the master stream.
// Requests are handled one at a time. After reset the block first clears its occupancy
// memory, one word per cycle, ceil(TABLE_DEPTH / W) words in all, where W is 32 (8 when the
// table has fewer than 32 slots); it takes no request until then. Occupancy is held as
// W-bit words in a memory with a registered read, so a free-slot search (allocate, find
// free) examines one word per cycle starting at the word of the search start (the hint,
// or for find a start index above it) until a free slot turns up or the last word is done.
// Assign, remove and lookup read the slot's occupancy word and data entry once. A request
// rejected on its indexes or code alone goes straight to its response. A request is
// taken while the previous response still waits in the output register; the block then
// holds its own response until that register frees.
module lowest_free_handle_table_core #(
    parameter int TABLE_DEPTH = lfht_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // From bit 0: command[2:0], slot_index[12:3], start_index[22:13], handle[54:23],
    // flags_in[70:55], zero fill[71].
    input  logic [lfht_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // Response stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // From bit 0: status[1:0], slot_out[10:2], handle_out[42:11], flags_out[58:43],
    // zero fill[63:59].
    output logic [lfht_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    // Geometry of the occupancy and data memories.
    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int HINT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CHUNK   = (TABLE_DEPTH >= 32) ? 32 : 8;
    localparam int POS_W   = $clog2(CHUNK);
    localparam int NWORDS  = (TABLE_DEPTH + CHUNK - 1) / CHUNK;
    localparam int WORD_AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int DATA_W  = lfht_pkg::HANDLE_W + lfht_pkg::FLAGS_W;
    localparam int WIDE_W  = lfht_pkg::WIDE_W;
    localparam logic [WIDE_W-1:0]  DEPTH_L   = WIDE_W'(TABLE_DEPTH);
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NWORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SLOT,
        S_DONE
    } t_state;

    // Request fields.
    logic [lfht_pkg::CMD_W-1:0]    w_in_cmd;
    logic [lfht_pkg::INDEX_W-1:0]  w_in_idx;
    logic [lfht_pkg::INDEX_W-1:0]  w_in_start;
    logic [lfht_pkg::HANDLE_W-1:0] w_in_handle;
    logic [lfht_pkg::FLAGS_W-1:0]  w_in_flags;

    assign w_in_cmd    = i_s_axis_tdata[2:0];
    assign w_in_idx    = i_s_axis_tdata[12:3];
    assign w_in_start  = i_s_axis_tdata[22:13];
    assign w_in_handle = i_s_axis_tdata[54:23];
    assign w_in_flags  = i_s_axis_tdata[70:55];

    // Control registers.
    t_state                        r_state, n_state;
    logic [WORD_AW-1:0]            r_clr_addr, n_clr_addr;
    lfht_pkg::t_cmd                r_cmd, n_cmd;
    logic [WIDE_W-1:0]             r_idx, n_idx;
    logic [WIDE_W-1:0]             r_from, n_from;
    logic [WORD_AW-1:0]            r_word, n_word;
    logic [lfht_pkg::HANDLE_W-1:0] r_handle, n_handle;
    logic [lfht_pkg::FLAGS_W-1:0]  r_flags, n_flags;
    logic [HINT_W-1:0]             r_hint, n_hint;

    // Staged response and output register.
    lfht_pkg::t_status             r_res_status, n_res_status;
    logic [WIDE_W-1:0]             r_res_slot, n_res_slot;
    logic [lfht_pkg::HANDLE_W-1:0] r_res_handle, n_res_handle;
    logic [lfht_pkg::FLAGS_W-1:0]  r_res_flags, n_res_flags;
    logic                          r_out_valid, n_out_valid;
    logic [lfht_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    // Memories and their ports.
    logic [CHUNK-1:0]  r_used_mem [NWORDS];
    logic [CHUNK-1:0]  r_used_rd;
    logic [DATA_W-1:0] r_data_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] r_data_rd;

    logic [WORD_AW-1:0] w_used_raddr;
    logic               w_used_we;
    logic [WORD_AW-1:0] w_used_waddr;
    logic [CHUNK-1:0]   w_used_wdata;
    logic [IDX_W-1:0]   w_data_raddr;
    logic               w_data_we;
    logic [IDX_W-1:0]   w_data_waddr;
    logic [DATA_W-1:0]  w_data_wdata;

    // Helper values.
    logic              w_accept;
    logic              w_out_free;
    logic [WIDE_W-1:0] w_in_idx_w;
    logic [WIDE_W-1:0] w_hint_w;
    logic [WIDE_W-1:0] w_from;
    logic [WIDE_W-1:0] w_word_base;
    logic [CHUNK-1:0]  w_free;
    logic              w_any_free;
    logic [POS_W-1:0]  w_free_pos;
    logic [WIDE_W-1:0] w_found;
    logic [POS_W-1:0]  w_slot_pos;
    logic [CHUNK-1:0]  w_slot_bit;
    logic              w_slot_used;

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign w_in_idx_w = WIDE_W'(w_in_idx);
    assign w_hint_w   = WIDE_W'(r_hint);

    // Search start: the hint, or for find the start index when that lies above the hint.
    always_comb begin
        if (lfht_pkg::t_cmd'(w_in_cmd) == lfht_pkg::CMD_FIND && WIDE_W'(w_in_start) > w_hint_w)
        begin
            w_from = WIDE_W'(w_in_start);
        end else begin
            w_from = w_hint_w;
        end
    end

    // Free slots in the occupancy word just read, limited to the search window.
    assign w_word_base = WIDE_W'(r_word) << POS_W;

    always_comb begin
        logic [WIDE_W-1:0] g;
        for (int p = 0; p < CHUNK; p++) begin
            g = w_word_base | WIDE_W'(p);
            w_free[p] = !r_used_rd[p] && (g >= r_from) && (g < DEPTH_L);
        end
    end

    assign w_any_free = |w_free;

    // Lowest free position in the word.
    always_comb begin
        w_free_pos = '0;
        for (int p = CHUNK - 1; p >= 0; p--) begin
            if (w_free[p]) begin
                w_free_pos = POS_W'(p);
            end
        end
    end

    assign w_found = w_word_base | WIDE_W'(w_free_pos);

    // Occupancy bit of the addressed slot.
    assign w_slot_pos  = r_idx[POS_W-1:0];
    assign w_slot_bit  = CHUNK'(1) << w_slot_pos;
    assign w_slot_used = r_used_rd[w_slot_pos];

    // Sequencer: next state, memory accesses and response.
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_from       = r_from;
        n_word       = r_word;
        n_handle     = r_handle;
        n_flags      = r_flags;
        n_hint       = r_hint;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_handle = r_res_handle;
        n_res_flags  = r_res_flags;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;

        w_used_raddr = r_word;
        w_used_we    = 1'b0;
        w_used_waddr = r_word;
        w_used_wdata = r_used_rd;
        w_data_raddr = r_idx[IDX_W-1:0];
        w_data_we    = 1'b0;
        w_data_waddr = r_idx[IDX_W-1:0];
        w_data_wdata = {r_flags, r_handle};

        unique case (r_state)
            // Clearing pass over the occupancy memory after reset.
            S_CLEAR: begin
                w_used_we    = 1'b1;
                w_used_waddr = r_clr_addr;
                w_used_wdata = '0;
                n_clr_addr   = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end

            // Take a request and issue the first memory reads.
            S_IDLE: begin
                w_used_raddr = WORD_AW'(w_in_idx_w >> POS_W);
                w_data_raddr = w_in_idx[IDX_W-1:0];
                if (w_accept) begin
                    n_cmd        = lfht_pkg::t_cmd'(w_in_cmd);
                    n_idx        = w_in_idx_w;
                    n_handle     = w_in_handle;
                    n_flags      = w_in_flags;
                    n_from       = w_from;
                    n_res_status = lfht_pkg::ST_FAIL;
                    n_res_slot   = DEPTH_L;
                    n_res_handle = '0;
                    n_res_flags  = '0;
                    n_state      = S_DONE;
                    unique case (lfht_pkg::t_cmd'(w_in_cmd))
                        lfht_pkg::CMD_ALLOC, lfht_pkg::CMD_FIND: begin
                            if (w_from < DEPTH_L) begin
                                w_used_raddr = WORD_AW'(w_from >> POS_W);
                                n_word       = WORD_AW'(w_from >> POS_W);
                                n_state      = S_SCAN;
                            end
                        end
                        lfht_pkg::CMD_ASSIGN, lfht_pkg::CMD_REMOVE, lfht_pkg::CMD_LOOKUP: begin
                            if (w_in_idx_w < DEPTH_L) begin
                                n_word  = WORD_AW'(w_in_idx_w >> POS_W);
                                n_state = S_SLOT;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // One occupancy word per cycle until a free slot turns up or the last word is examined.
            S_SCAN: begin
                w_used_raddr = r_word + 1'b1;
                if (w_any_free) begin
                    n_res_status = lfht_pkg::ST_OK;
                    n_res_slot   = w_found;
                    n_state      = S_DONE;
                    if (r_cmd == lfht_pkg::CMD_ALLOC) begin
                        w_used_we    = 1'b1;
                        w_used_wdata = r_used_rd | (CHUNK'(1) << w_free_pos);
                        w_data_we    = 1'b1;
                        w_data_waddr = w_found[IDX_W-1:0];
                        if (w_found == w_hint_w) begin
                            n_hint = r_hint + 1'b1;
                        end
                    end
                end else if (r_word == LAST_WORD) begin
                    n_state = S_DONE;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end

            // Read-modify-write of one addressed slot.
            S_SLOT: begin
                n_res_slot = r_idx;
                n_state    = S_DONE;
                unique case (r_cmd)
                    lfht_pkg::CMD_ASSIGN: begin
                        if (w_slot_used) begin
                            n_res_status = lfht_pkg::ST_OCCUPIED;
                        end else begin
                            n_res_status = lfht_pkg::ST_OK;
                            w_used_we    = 1'b1;
                            w_used_wdata = r_used_rd | w_slot_bit;
                            w_data_we    = 1'b1;
                            if (r_idx == w_hint_w) begin
                                n_hint = r_hint + 1'b1;
                            end
                        end
                    end
                    lfht_pkg::CMD_REMOVE: begin
                        if (w_slot_used) begin
                            n_res_status = lfht_pkg::ST_OK;
                            n_res_handle = r_data_rd[lfht_pkg::HANDLE_W-1:0];
                        end else begin
                            n_res_status = lfht_pkg::ST_EMPTY;
                        end
                        w_used_we    = 1'b1;
                        w_used_wdata = r_used_rd & ~w_slot_bit;
                        if (r_idx < w_hint_w) begin
                            n_hint = HINT_W'(r_idx);
                        end
                    end
                    lfht_pkg::CMD_LOOKUP: begin
                        if (w_slot_used) begin
                            n_res_status = lfht_pkg::ST_OK;
                            n_res_handle = r_data_rd[lfht_pkg::HANDLE_W-1:0];
                            n_res_flags  = r_data_rd[DATA_W-1:lfht_pkg::HANDLE_W];
                        end else begin
                            n_res_status = lfht_pkg::ST_EMPTY;
                        end
                    end
                    default: begin
                        n_res_status = lfht_pkg::ST_FAIL;
                        n_res_slot   = DEPTH_L;
                    end
                endcase
            end

            // Hand the response to the output register once it is free.
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = lfht_pkg::OUT_DATA_W'({r_res_flags, r_res_handle,
                                                         r_res_slot[lfht_pkg::SLOT_W-1:0],
                                                         r_res_status});
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_from       <= n_from;
        r_word       <= n_word;
        r_handle     <= n_handle;
        r_flags      <= n_flags;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_handle <= n_res_handle;
        r_res_flags  <= n_res_flags;
        r_out_data   <= n_out_data;
    end

    // Occupancy memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_used_we) begin
            r_used_mem[w_used_waddr] <= w_used_wdata;
        end
        r_used_rd <= r_used_mem[w_used_raddr];
    end

    // Handle and flags memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_data_we) begin
            r_data_mem[w_data_waddr] <= w_data_wdata;
        end
        r_data_rd <= r_data_mem[w_data_raddr];
    end

    // The hint never passes the table depth.
    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WIDE_W'(r_hint) <= DEPTH_L))
        else $error("search hint beyond table depth");

    // Only one request is in flight: a transfer in closes the request side.
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("request taken while another is in progress");

    // A failed response always names no slot.
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status == lfht_pkg::ST_FAIL) |-> (r_res_slot == DEPTH_L))
        else $error("failed response carries a slot");

    // Memory writes happen only while clearing or when a request modifies a slot.
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_used_we || w_data_we) |->
            (r_state == S_CLEAR || r_state == S_SCAN || r_state == S_SLOT))
        else $error("memory written outside a modify step");

    // A slot found by a scan lies inside the table and at or above the search start.
    a_scan_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_any_free) |-> (w_found < DEPTH_L && w_found >= r_from))
        else $error("scan result outside its window");

endmodule

[tb/sv/tb_lowest_free_handle_table_core.sv]
// Self-checking testbench for the lowest-free handle table core.
module tb_lowest_free_handle_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = lfht_pkg::TABLE_DEPTH_DEF;
    localparam int IDLE_PCT       = 30;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_SETTLE     = 20;

    typedef logic [lfht_pkg::CMD_W-1:0]      t_cmd_code;
    typedef logic [lfht_pkg::INDEX_W-1:0]    t_index;
    typedef logic [lfht_pkg::HANDLE_W-1:0]   t_handle;
    typedef logic [lfht_pkg::FLAGS_W-1:0]    t_flags;
    typedef logic [lfht_pkg::SLOT_W-1:0]     t_slot;
    typedef logic [lfht_pkg::STATUS_W-1:0]   t_status_code;
    typedef logic [lfht_pkg::IN_DATA_W-1:0]  t_in_data;
    typedef logic [lfht_pkg::OUT_DATA_W-1:0] t_out_data;

    // Command codes that the block does not know.
    localparam t_cmd_code CMD_UNUSED_LO = 3'd5;
    localparam t_cmd_code CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        t_flags       flags_out;
        t_handle      handle_out;
        t_slot        slot_out;
        t_status_code status;
    } t_response;

    logic      i_clk    = 1'b0;
    logic      i_rst_n  = 1'b0;
    logic      s_tvalid = 1'b0;
    t_in_data  s_tdata  = '0;
    logic      m_tready = 1'b0;
    logic      o_s_axis_tready;
    logic      o_m_axis_tvalid;
    t_out_data o_m_axis_tdata;

    // Shadow copy of the table kept by the predictor.
    bit      slot_used [DEPTH];
    t_handle slot_handle [DEPTH];
    t_flags  slot_flags [DEPTH];
    int      free_hint;
    int      used_count;

    t_response expected_responses[$];
    int        mismatch_count;
    bit        steady;
    int        holds_asked;
    int        holds_granted;
    int        hold_left;
    int        quiet_cycles;

    lowest_free_handle_table_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // First free slot at or after a start point, never below the hint; DEPTH if none.
    function automatic int lowest_free_from(input int from);
        int i;
        i = (from < free_hint) ? free_hint : from;
        while (i < DEPTH && slot_used[i])
            i++;
        return i;
    endfunction

    // Fill a slot and step the hint past it when it was the hinted one.
    function automatic void occupy_slot(input int s, input t_handle h, input t_flags f);
        slot_used[s]   = 1'b1;
        slot_handle[s] = h;
        slot_flags[s]  = f;
        used_count++;
        if (s == free_hint)
            free_hint++;
    endfunction

    // Work out the response to one request and update the shadow table.
    function automatic t_response predict_response(input t_cmd_code cmd,
                                                   input t_index idx,
                                                   input t_index start,
                                                   input t_handle h,
                                                   input t_flags f);
        t_response r;
        int        s;
        r.status     = lfht_pkg::ST_FAIL;
        r.slot_out   = t_slot'(DEPTH);
        r.handle_out = '0;
        r.flags_out  = '0;
        unique case (cmd)
            lfht_pkg::CMD_ALLOC: begin
                s = lowest_free_from(0);
                if (s < DEPTH) begin
                    occupy_slot(s, h, f);
                    r.status   = lfht_pkg::ST_OK;
                    r.slot_out = t_slot'(s);
                end
            end
            lfht_pkg::CMD_ASSIGN: begin
                if (idx < DEPTH) begin
                    r.slot_out = t_slot'(idx);
                    if (slot_used[idx]) begin
                        r.status = lfht_pkg::ST_OCCUPIED;
                    end else begin
                        occupy_slot(int'(idx), h, f);
                        r.status = lfht_pkg::ST_OK;
                    end
                end
            end
            lfht_pkg::CMD_REMOVE: begin
                if (idx < DEPTH) begin
                    r.slot_out = t_slot'(idx);
                    if (slot_used[idx]) begin
                        r.handle_out = slot_handle[idx];
                        r.status     = lfht_pkg::ST_OK;
                        used_count--;
                    end else begin
                        r.status = lfht_pkg::ST_EMPTY;
                    end
                    slot_used[idx] = 1'b0;
                    // The hint drops to the removed slot even when it was already empty.
                    if (idx < free_hint)
                        free_hint = int'(idx);
                end
            end
            lfht_pkg::CMD_LOOKUP: begin
                if (idx < DEPTH) begin
                    r.slot_out = t_slot'(idx);
                    if (slot_used[idx]) begin
                        r.handle_out = slot_handle[idx];
                        r.flags_out  = slot_flags[idx];
                        r.status     = lfht_pkg::ST_OK;
                    end else begin
                        r.status = lfht_pkg::ST_EMPTY;
                    end
                end
            end
            lfht_pkg::CMD_FIND: begin
                s = lowest_free_from(int'(start));
                if (s < DEPTH) begin
                    r.status   = lfht_pkg::ST_OK;
                    r.slot_out = t_slot'(s);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        $display("mismatch: %s expected 0x%0h got 0x%0h", what, want, got);
        mismatch_count++;
    endtask

    // Offer one request, wait for its transfer and record the expected response.
    task automatic send_request(input t_cmd_code cmd,
                                input t_index slot_index,
                                input t_index start_index,
                                input t_handle handle,
                                input t_flags flags);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t_in_data'({flags, handle, start_index, slot_index, cmd});
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        expected_responses.push_back(
            predict_response(cmd, slot_index, start_index, handle, flags));
    endtask

    // Random content around a given command; wide indexes reach past the table.
    task automatic send_random(input t_cmd_code cmd, input bit wide);
        t_index idx;
        t_index start;
        idx   = wide ? t_index'($urandom_range(1023)) : t_index'($urandom_range(DEPTH - 1));
        start = ($urandom_range(99) < 20) ? t_index'($urandom_range(1023))
                                          : t_index'($urandom_range(DEPTH - 1));
        send_request(cmd, idx, start, $urandom, t_flags'($urandom_range(16'hFFFF)));
    endtask

    // An unknown code, or an assign, remove or lookup with an index that may reach past the table.
    task automatic send_noise();
        if ($urandom_range(1) != 0)
            send_random(t_cmd_code'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)),
                        ($urandom_range(1) != 0));
        else
            send_random(t_cmd_code'($urandom_range(lfht_pkg::CMD_LOOKUP,
                                                   lfht_pkg::CMD_ASSIGN)), 1'b1);
    endtask

    // Field extremes and every special case on a nearly empty table.
    task automatic test_directed_cases();
        send_request(lfht_pkg::CMD_ALLOC, '0, '0, '0, '0);
        send_request(lfht_pkg::CMD_ALLOC, '1, '1, '1, '1);
        send_request(lfht_pkg::CMD_ASSIGN, t_index'(DEPTH - 1), '0, 32'hA5A5_5A5A, 16'h5AA5);
        send_request(lfht_pkg::CMD_ASSIGN, t_index'(1), '0, $urandom,
                     t_flags'($urandom_range(16'hFFFF)));
        send_request(lfht_pkg::CMD_ASSIGN, t_index'(DEPTH), '0, $urandom,
                     t_flags'($urandom_range(16'hFFFF)));
        send_request(lfht_pkg::CMD_ASSIGN, '1, '0, $urandom,
                     t_flags'($urandom_range(16'hFFFF)));
        send_request(lfht_pkg::CMD_LOOKUP, t_index'(1), '1, '0, '0);
        send_request(lfht_pkg::CMD_LOOKUP, t_index'(2), '0, '1, '1);
        send_request(lfht_pkg::CMD_LOOKUP, '1, '0, '0, '0);
        send_request(lfht_pkg::CMD_REMOVE, '0, '0, '0, '0);
        send_request(lfht_pkg::CMD_REMOVE, '0, '0, '0, '0);
        send_request(lfht_pkg::CMD_REMOVE, '1, '0, '0, '0);
        send_request(lfht_pkg::CMD_FIND, '0, '0, '0, '0);
        send_request(lfht_pkg::CMD_FIND, '0, t_index'(DEPTH - 1), '0, '0);
        send_request(lfht_pkg::CMD_FIND, '0, t_index'(DEPTH), '0, '0);
        send_request(lfht_pkg::CMD_FIND, '0, '1, '0, '0);
        send_request(lfht_pkg::CMD_ALLOC, '0, '0, 32'h0000_0001, 16'h8000);
        send_request(lfht_pkg::CMD_ASSIGN, t_index'(2), '0, 32'h8000_0000, 16'h0001);
        send_request(lfht_pkg::CMD_REMOVE, t_index'(DEPTH - 1), '0, '0, '0);
        for (int c = int'(CMD_UNUSED_LO); c <= int'(CMD_UNUSED_HI); c++)
            send_request(t_cmd_code'(c), t_index'($urandom_range(1023)),
                         t_index'($urandom_range(1023)), $urandom,
                         t_flags'($urandom_range(16'hFFFF)));
        send_request(lfht_pkg::CMD_LOOKUP, t_index'(DEPTH - 1), '0, '0, '0);
        send_request(lfht_pkg::CMD_ALLOC, '0, '0, $urandom, t_flags'($urandom_range(16'hFFFF)));
        send_request(lfht_pkg::CMD_LOOKUP, t_index'(2), '0, '0, '0);
    endtask

    // Mostly allocations until every slot is taken or 450 requests are sent; the opening stretch runs without gaps.
    task automatic test_fill_to_full();
        int roll;
        int sent;
        sent   = 0;
        steady = 1'b1;
        while (used_count < DEPTH && sent < 450) begin
            if (sent == 80)
                steady = 1'b0;
            roll = $urandom_range(99);
            if (roll < 78)
                send_random(lfht_pkg::CMD_ALLOC, 1'b0);
            else if (roll < 88)
                send_random(lfht_pkg::CMD_ASSIGN, 1'b0);
            else if (roll < 92)
                send_random(lfht_pkg::CMD_LOOKUP, 1'b0);
            else if (roll < 96)
                send_random(lfht_pkg::CMD_FIND, 1'b0);
            else if (roll < 98)
                send_random(lfht_pkg::CMD_REMOVE, 1'b0);
            else
                send_noise();
            sent++;
        end
        steady = 1'b0;
    endtask

    // Requests on a full table, then the last slot is freed and searched for and allocated again.
    task automatic test_full_table();
        repeat (3) send_random(lfht_pkg::CMD_ALLOC, 1'b0);
        send_request(lfht_pkg::CMD_FIND, '0, '0, '0, '0);
        send_random(lfht_pkg::CMD_FIND, 1'b0);
        send_random(lfht_pkg::CMD_ASSIGN, 1'b0);
        send_random(lfht_pkg::CMD_LOOKUP, 1'b0);
        send_request(lfht_pkg::CMD_REMOVE, t_index'(DEPTH - 1), '0, '0, '0);
        send_request(lfht_pkg::CMD_FIND, '0, '0, '0, '0);
        send_random(lfht_pkg::CMD_ALLOC, 1'b0);
    endtask

    // A random mix of commands with the rough weights given.
    task automatic send_churn();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35)
            send_random(lfht_pkg::CMD_REMOVE, 1'b0);
        else if (roll < 55)
            send_random(lfht_pkg::CMD_ALLOC, 1'b0);
        else if (roll < 70)
            send_random(lfht_pkg::CMD_LOOKUP, 1'b0);
        else if (roll < 80)
            send_random(lfht_pkg::CMD_FIND, 1'b0);
        else if (roll < 92)
            send_random(lfht_pkg::CMD_ASSIGN, 1'b0);
        else
            send_noise();
    endtask

    // The receiver holds off for a long stretch while requests keep coming without gaps.
    task automatic test_output_hold_off();
        steady = 1'b1;
        holds_asked++;
        repeat (30) send_churn();
        steady = 1'b0;
    endtask

    // Mixed traffic that drains the table and refills holes below the hint.
    task automatic test_mixed_churn();
        repeat (200) send_churn();
    endtask

    // Check each response transfer and drive the receiver ready.
    always @(posedge i_clk) begin : response_side
        t_response got;
        t_response want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got = o_m_axis_tdata[lfht_pkg::OUT_BITS-1:0];
            if (expected_responses.size() == 0) begin
                report_mismatch("unexpected response", '0, 64'(o_m_axis_tdata));
            end else begin
                want = expected_responses.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(want.status), 64'(got.status));
                if (got.slot_out !== want.slot_out)
                    report_mismatch("slot_out", 64'(want.slot_out), 64'(got.slot_out));
                if (got.handle_out !== want.handle_out)
                    report_mismatch("handle_out", 64'(want.handle_out), 64'(got.handle_out));
                if (got.flags_out !== want.flags_out)
                    report_mismatch("flags_out", 64'(want.flags_out), 64'(got.flags_out));
            end
        end
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_granted != holds_asked) begin
            m_tready      <= 1'b0;
            hold_left     <= LONG_HOLD;
            holds_granted <= holds_granted + 1;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles without any transfer on either side.
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        free_hint  = 0;
        used_count = 0;
        for (int i = 0; i < DEPTH; i++)
            slot_used[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_fill_to_full();
        test_full_table();
        test_output_hold_off();
        test_mixed_churn();
        s_tvalid <= 1'b0;

        // Drain outstanding responses, then allow a little settling time.
        while (expected_responses.size() != 0)
            @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && expected_responses.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
